>>> sv/tfms_pkg.sv
// Package for the plane-wave field summation block: widths, field offsets,
// polynomial constants and the sequencer state type. No dependencies.
package tfms_pkg;

    localparam int NUM_MODES_DEF      = 4096;
    localparam int COS_TABLE_BITS_DEF = 10;

    // Quarter-wave sine polynomial coefficients (Q15 based)
    localparam logic [16:0] POLY_A = 17'd51472;
    localparam logic [16:0] POLY_B = 17'd21167;
    localparam logic [16:0] POLY_C = 17'd2611;
    localparam logic [16:0] HALF_TURN_Q15 = 17'd32768;
    localparam logic [16:0] COS_MAX = 17'd32767;

    // Input tdata layout, lowest bit first
    localparam int IN_TDATA_W = 296;
    localparam int MIDX_LO = 0;
    localparam int KX_LO   = 12;
    localparam int KY_LO   = 44;
    localparam int KZ_LO   = 76;
    localparam int PH_LO   = 108;
    localparam int AX_LO   = 124;
    localparam int AY_LO   = 148;
    localparam int AZ_LO   = 172;
    localparam int PX_LO   = 196;
    localparam int PY_LO   = 228;
    localparam int PZ_LO   = 260;
    localparam int OUT_TDATA_W = 96;

    // One stored mode row
    localparam int ROW_W = 184;

    // Command codes carried in tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_BRMS  = 2'd0;
    localparam logic [1:0] CFG_BIAS  = 2'd1;
    localparam logic [1:0] CFG_MODES = 2'd2;

    localparam logic [15:0] BRMS_RST  = 16'd256;
    localparam logic [12:0] MODES_RST = 13'd4096;

    // Component selector during output scaling
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic signed [31:0] kx;
        logic signed [31:0] ky;
        logic signed [31:0] kz;
        logic [15:0]        phase;
        logic signed [23:0] ax;
        logic signed [23:0] ay;
        logic signed [23:0] az;
    } mode_row_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_DX,
        ST_DY,
        ST_DZ,
        ST_TH,
        ST_SQ,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_CS,
        ST_AX,
        ST_AY,
        ST_AZ,
        ST_AC,
        ST_SLO,
        ST_SHI,
        ST_SSUM,
        ST_SFIN,
        ST_PUSH
    } state_t;

endpackage

>>> sv/tfms_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tfms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/turbulent_field_mode_summation.sv
// Plane-wave field summation: top level with the mode table and the sequencer
// driving one shared 33x33 multiplier. Depends on tfms_pkg and tfms_ram.
//
// Load transaction: written to the table, ready again the next cycle.
// Evaluate transaction: per mode in use, the row is read and phase, cosine and
// amplitude products accumulated; each component is then scaled and the result
// pushed once any held result is taken, and only then is the input ready again.
// Reset (rst_n low, asynchronous) clears control and sums, sets brms and modes
// to defaults and leaves datapath and mode table unreset (garbage until loaded).
module turbulent_field_mode_summation #(
    parameter int NUM_MODES      = tfms_pkg::NUM_MODES_DEF,
    parameter int COS_TABLE_BITS = tfms_pkg::COS_TABLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // fields from bit 0: mode_index, k_x, k_y, k_z, phase_in, amp_x, amp_y,
    // amp_z, pos_x, pos_y, pos_z, zero pad
    input  logic [tfms_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // fields from bit 0: cmd
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fields from bit 0: field_x, field_y, field_z
    output logic [tfms_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
    localparam int CW = $clog2(NUM_MODES + 1);
    localparam int RW = COS_TABLE_BITS - 2;

    tfms_pkg::state_t state_reg, state_next;

    logic [15:0]        brms_reg;
    logic signed [31:0] bias_reg;
    logic [12:0]        modes_reg;

    logic [CW-1:0]      walk_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      walk_inc;
    logic               last_mode;

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [31:0]        theta_reg;
    logic [16:0]        v_reg, v2_reg;
    logic [1:0]         quad_reg;
    logic signed [16:0] c_reg;
    logic [47:0]        prod_reg;
    logic [47:0]        acc_x_reg, acc_y_reg, acc_z_reg;
    logic [39:0]        lo_reg;
    logic signed [55:0] scaled_reg;
    logic [1:0]         comp_reg;
    logic [31:0]        fx_reg, fy_reg, fz_reg;
    logic               out_valid_reg;
    logic [tfms_pkg::OUT_TDATA_W-1:0] out_data_reg;

    // Shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    logic               in_fire;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [tfms_pkg::ROW_W-1:0] ram_wdata, ram_rdata;
    tfms_pkg::mode_row_t row;

    logic [COS_TABLE_BITS-1:0] cos_idx;
    logic [RW-1:0]      cos_r;
    logic [14:0]        cos_u;
    logic [16:0]        cos_v;
    logic [16:0]        prod_q;
    logic [16:0]        poly_t;
    logic [16:0]        s_clamped;
    logic [47:0]        acc_sel;
    logic [63:0]        scale_sum;
    logic signed [56:0] fin_val;
    logic [31:0]        fin_sat;
    logic [CW-1:0]      count_eff;

    assign s_axis_tready = (state_reg == tfms_pkg::ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Mode table: write on in-range load transactions, read the row at the walk index
    assign ram_we    = in_fire && (s_axis_tuser == tfms_pkg::CMD_LOAD)
                       && ({20'd0, s_axis_tdata[tfms_pkg::MIDX_LO +: 12]} < NUM_MODES);
    assign ram_waddr = AW'(s_axis_tdata[tfms_pkg::MIDX_LO +: 12]);
    assign ram_wdata = {s_axis_tdata[tfms_pkg::KX_LO +: 32],
                        s_axis_tdata[tfms_pkg::KY_LO +: 32],
                        s_axis_tdata[tfms_pkg::KZ_LO +: 32],
                        s_axis_tdata[tfms_pkg::PH_LO +: 16],
                        s_axis_tdata[tfms_pkg::AX_LO +: 24],
                        s_axis_tdata[tfms_pkg::AY_LO +: 24],
                        s_axis_tdata[tfms_pkg::AZ_LO +: 24]};

    tfms_ram #(
        .WIDTH (tfms_pkg::ROW_W),
        .DEPTH (NUM_MODES),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (walk_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    assign row = tfms_pkg::mode_row_t'(ram_rdata);

    // Clamp the configured mode count to the table depth
    assign count_eff = ({19'd0, modes_reg} > NUM_MODES) ? CW'(NUM_MODES) : CW'(modes_reg);

    assign walk_inc  = walk_reg + CW'(1);
    assign last_mode = (walk_inc == count_reg);

    // Cosine index split: quadrant and offset within the quarter wave
    assign cos_idx = theta_reg[31 -: COS_TABLE_BITS];
    assign cos_r   = cos_idx[RW-1:0];
    assign cos_u   = 15'(cos_r) << (15 - RW);
    assign cos_v   = (cos_idx[COS_TABLE_BITS-1 -: 2] == 2'd0 ||
                      cos_idx[COS_TABLE_BITS-1 -: 2] == 2'd2)
                     ? (tfms_pkg::HALF_TURN_Q15 - {2'b00, cos_u}) : {2'b00, cos_u};

    assign prod_q    = prod_reg[31:15];
    assign poly_t    = (state_reg == tfms_pkg::ST_P2) ? (tfms_pkg::POLY_B - prod_q)
                                                      : (tfms_pkg::POLY_A - prod_q);
    assign s_clamped = (prod_q > tfms_pkg::COS_MAX) ? tfms_pkg::COS_MAX : prod_q;

    always_comb
    begin
        case (comp_reg)
            tfms_pkg::COMP_X: acc_sel = acc_x_reg;
            tfms_pkg::COMP_Y: acc_sel = acc_y_reg;
            default:          acc_sel = acc_z_reg;
        endcase
    end

    // Recombine the two partial products of acc * brms, then drop 8 bits
    assign scale_sum = {{24{prod_reg[39]}}, prod_reg[39:0]} <<< 24;
    assign fin_val   = 57'(scaled_reg) + ((comp_reg == tfms_pkg::COMP_Z)
                       ? 57'(bias_reg) : 57'sd0);
    assign fin_sat   = (fin_val > 57'sd2147483647) ? 32'h7FFF_FFFF :
                       (fin_val < -57'sd2147483648) ? 32'h8000_0000 : fin_val[31:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tfms_pkg::ST_IDLE:
            begin
                if (in_fire && s_axis_tuser == tfms_pkg::CMD_EVAL)
                begin
                    state_next = (count_eff == '0) ? tfms_pkg::ST_SLO : tfms_pkg::ST_READ;
                end
            end
            tfms_pkg::ST_READ: state_next = tfms_pkg::ST_DX;
            tfms_pkg::ST_DX:   state_next = tfms_pkg::ST_DY;
            tfms_pkg::ST_DY:   state_next = tfms_pkg::ST_DZ;
            tfms_pkg::ST_DZ:   state_next = tfms_pkg::ST_TH;
            tfms_pkg::ST_TH:   state_next = tfms_pkg::ST_SQ;
            tfms_pkg::ST_SQ:   state_next = tfms_pkg::ST_P1;
            tfms_pkg::ST_P1:   state_next = tfms_pkg::ST_P2;
            tfms_pkg::ST_P2:   state_next = tfms_pkg::ST_P3;
            tfms_pkg::ST_P3:   state_next = tfms_pkg::ST_CS;
            tfms_pkg::ST_CS:   state_next = tfms_pkg::ST_AX;
            tfms_pkg::ST_AX:   state_next = tfms_pkg::ST_AY;
            tfms_pkg::ST_AY:   state_next = tfms_pkg::ST_AZ;
            tfms_pkg::ST_AZ:   state_next = tfms_pkg::ST_AC;
            tfms_pkg::ST_AC:   state_next = last_mode ? tfms_pkg::ST_SLO : tfms_pkg::ST_READ;
            tfms_pkg::ST_SLO:  state_next = tfms_pkg::ST_SHI;
            tfms_pkg::ST_SHI:  state_next = tfms_pkg::ST_SSUM;
            tfms_pkg::ST_SSUM: state_next = tfms_pkg::ST_SFIN;
            tfms_pkg::ST_SFIN:
            begin
                state_next = (comp_reg == tfms_pkg::COMP_Z) ? tfms_pkg::ST_PUSH
                                                            : tfms_pkg::ST_SLO;
            end
            tfms_pkg::ST_PUSH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = tfms_pkg::ST_IDLE;
                end
            end
            default: state_next = tfms_pkg::ST_IDLE;
        endcase
    end

    // Multiplier operand selection per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            tfms_pkg::ST_DX:
            begin
                mul_a = 33'(row.kx);
                mul_b = 33'(px_reg);
            end
            tfms_pkg::ST_DY:
            begin
                mul_a = 33'(row.ky);
                mul_b = 33'(py_reg);
            end
            tfms_pkg::ST_DZ:
            begin
                mul_a = 33'(row.kz);
                mul_b = 33'(pz_reg);
            end
            tfms_pkg::ST_SQ:
            begin
                mul_a = {16'd0, cos_v};
                mul_b = {16'd0, cos_v};
            end
            tfms_pkg::ST_P1:
            begin
                mul_a = {16'd0, tfms_pkg::POLY_C};
                mul_b = {16'd0, prod_q};
            end
            tfms_pkg::ST_P2:
            begin
                mul_a = {16'd0, poly_t};
                mul_b = {16'd0, v2_reg};
            end
            tfms_pkg::ST_P3:
            begin
                mul_a = {16'd0, poly_t};
                mul_b = {16'd0, v_reg};
            end
            tfms_pkg::ST_AX:
            begin
                mul_a = 33'(row.ax);
                mul_b = 33'(c_reg);
            end
            tfms_pkg::ST_AY:
            begin
                mul_a = 33'(row.ay);
                mul_b = 33'(c_reg);
            end
            tfms_pkg::ST_AZ:
            begin
                mul_a = 33'(row.az);
                mul_b = 33'(c_reg);
            end
            tfms_pkg::ST_SLO:
            begin
                mul_a = {9'd0, acc_sel[23:0]};
                mul_b = {17'd0, brms_reg};
            end
            tfms_pkg::ST_SHI:
            begin
                mul_a = 33'($signed(acc_sel[47:24]));
                mul_b = {17'd0, brms_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfms_pkg::ST_IDLE;
            brms_reg      <= tfms_pkg::BRMS_RST;
            bias_reg      <= '0;
            modes_reg     <= tfms_pkg::MODES_RST;
            walk_reg      <= '0;
            count_reg     <= '0;
            comp_reg      <= tfms_pkg::COMP_X;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_z_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tfms_pkg::CFG_BRMS:  brms_reg  <= cfg_data[15:0];
                    tfms_pkg::CFG_BIAS:  bias_reg  <= cfg_data;
                    tfms_pkg::CFG_MODES: modes_reg <= cfg_data[12:0];
                    default: ;
                endcase
            end

            // Raise valid when the result is pushed, drop it once taken
            if (state_reg == tfms_pkg::ST_PUSH && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                tfms_pkg::ST_IDLE:
                begin
                    if (in_fire && s_axis_tuser == tfms_pkg::CMD_EVAL)
                    begin
                        count_reg <= count_eff;
                        comp_reg  <= tfms_pkg::COMP_X;
                        acc_x_reg <= '0;
                        acc_y_reg <= '0;
                        acc_z_reg <= '0;
                    end
                end
                tfms_pkg::ST_AY: acc_x_reg <= acc_x_reg + 48'($signed(prod_reg) >>> 15);
                tfms_pkg::ST_AZ: acc_y_reg <= acc_y_reg + 48'($signed(prod_reg) >>> 15);
                tfms_pkg::ST_AC:
                begin
                    acc_z_reg <= acc_z_reg + 48'($signed(prod_reg) >>> 15);
                    walk_reg  <= last_mode ? '0 : walk_inc;
                end
                tfms_pkg::ST_SFIN:
                begin
                    comp_reg <= comp_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p[47:0];
        if (in_fire)
        begin
            px_reg <= s_axis_tdata[tfms_pkg::PX_LO +: 32];
            py_reg <= s_axis_tdata[tfms_pkg::PY_LO +: 32];
            pz_reg <= s_axis_tdata[tfms_pkg::PZ_LO +: 32];
        end
        case (state_reg)
            tfms_pkg::ST_DY: theta_reg <= {row.phase, 16'd0} + prod_reg[31:0];
            tfms_pkg::ST_DZ: theta_reg <= theta_reg + prod_reg[31:0];
            tfms_pkg::ST_TH: theta_reg <= theta_reg + prod_reg[31:0];
            tfms_pkg::ST_SQ:
            begin
                v_reg    <= cos_v;
                quad_reg <= cos_idx[COS_TABLE_BITS-1 -: 2];
            end
            tfms_pkg::ST_P1: v2_reg <= prod_q;
            tfms_pkg::ST_CS:
            begin
                // negate in the second and third quadrants
                c_reg <= (quad_reg == 2'd1 || quad_reg == 2'd2) ? -$signed(s_clamped)
                                                                 : $signed(s_clamped);
            end
            tfms_pkg::ST_SHI:  lo_reg <= prod_reg[39:0];
            tfms_pkg::ST_SSUM: scaled_reg <= 56'($signed(scale_sum + {24'd0, lo_reg}) >>> 8);
            tfms_pkg::ST_SFIN:
            begin
                case (comp_reg)
                    tfms_pkg::COMP_X: fx_reg <= fin_sat;
                    tfms_pkg::COMP_Y: fy_reg <= fin_sat;
                    default:          fz_reg <= fin_sat;
                endcase
            end
            tfms_pkg::ST_PUSH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_reg <= {fz_reg, fy_reg, fx_reg};
                end
            end
            default: ;
        endcase
    end

endmodule

>>> sv/tfms_checker.sv
// Port-level checker for the field summation block, with its bind.
// Depends on tfms_pkg and turbulent_field_mode_summation.
module tfms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [tfms_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A load transaction leaves the block ready on the next cycle
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == tfms_pkg::CMD_LOAD
        |=> s_axis_tready)
        else $error("not ready after load");

    // An evaluate transaction makes the block busy
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == tfms_pkg::CMD_EVAL
        |=> !s_axis_tready)
        else $error("ready right after evaluate");

    // No result is offered during reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid in reset");

endmodule

bind turbulent_field_mode_summation tfms_checker u_tfms_checker (.*);

>>> dv/tb_turbulent_field_mode_summation.sv
// Self-checking testbench for the plane-wave field summation block.
// Drives mode loads, evaluations and register writes, and checks every result
// against a given or predicted value. Depends on tfms_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_turbulent_field_mode_summation;

    localparam int          TBL_DEPTH   = tfms_pkg::NUM_MODES_DEF;
    localparam int          COS_BITS    = tfms_pkg::COS_TABLE_BITS_DEF;
    localparam longint      CYCLE_LIMIT = 3000000;
    localparam int          HOLD_CYCLES = 3000;
    localparam int          TARGET_ITEMS = 140;
    // Entries loaded before the random part; covers every mode count used there
    localparam int          FILL_MODES  = 16;
    // Index 3 maps to no register; writing it must change nothing.
    localparam logic [1:0]  CFG_UNUSED  = 2'd3;

    typedef struct {
        logic               cmd;
        logic [11:0]        idx;
        logic signed [31:0] kx, ky, kz;
        logic [15:0]        ph;
        logic signed [23:0] ax, ay, az;
        logic signed [31:0] px, py, pz;
    } mode_item_t;

    typedef struct {
        logic signed [31:0] fx, fy, fz;
    } field_t;

    typedef struct {
        logic       is_cfg;
        logic [1:0] reg_idx;
        logic [31:0] reg_val;
        mode_item_t it;
        logic       typed;
        field_t     want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [tfms_pkg::IN_TDATA_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [tfms_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    turbulent_field_mode_summation dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Shadow of the block: mode table and registers
    logic signed [31:0] sh_kx [TBL_DEPTH];
    logic signed [31:0] sh_ky [TBL_DEPTH];
    logic signed [31:0] sh_kz [TBL_DEPTH];
    logic [15:0]        sh_ph [TBL_DEPTH];
    logic signed [23:0] sh_ax [TBL_DEPTH];
    logic signed [23:0] sh_ay [TBL_DEPTH];
    logic signed [23:0] sh_az [TBL_DEPTH];
    logic [15:0]        sh_brms;
    logic signed [31:0] sh_bias;
    logic [12:0]        sh_modes;

    field_t     pending_fields[$];
    stim_row_t  directed[$];
    int         mismatches = 0;
    int         burst_left;
    int         items_sent;
    logic       hold_req;
    logic       hold_taken;
    int         hold_left;
    longint     cyc = 0;

    // sin(pi/2 * v / 2^15) in Q15, v in [0, 32768]
    function automatic longint unsigned quarter_wave(input longint unsigned v);
        longint unsigned v2, t;
        v2 = (v * v) >> 15;
        t  = (longint'(tfms_pkg::POLY_C) * v2) >> 15;
        t  = longint'(tfms_pkg::POLY_B) - t;
        t  = (t * v2) >> 15;
        t  = longint'(tfms_pkg::POLY_A) - t;
        return (t * v) >> 15;
    endfunction

    function automatic longint cos_q15(input logic [31:0] theta);
        logic [31:0] j, quad, r;
        longint unsigned u;
        longint s;
        j    = theta >> (32 - COS_BITS);
        quad = (j >> (COS_BITS - 2)) & 32'd3;
        r    = j & ((32'd1 << (COS_BITS - 2)) - 1);
        u    = longint'(r) << (15 - (COS_BITS - 2));
        if (quad == 0 || quad == 2)
            s = longint'(quarter_wave(32768 - u));
        else
            s = longint'(quarter_wave(u));
        if (s > 32767)
            s = 32767;
        if (quad == 1 || quad == 2)
            s = -s;
        return s;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Sum amp * cos(k . pos + phase) over the modes in use, then scale; bias z only
    function automatic field_t sum_modes(input mode_item_t it);
        field_t f;
        logic [47:0] acx, acy, acz;
        logic [31:0] th;
        longint c, p, brms, sx, sy, sz;
        int count;
        acx = '0;
        acy = '0;
        acz = '0;
        count = (sh_modes > TBL_DEPTH) ? TBL_DEPTH : sh_modes;
        for (int m = 0; m < count; m++)
        begin
            th = sh_kx[m] * it.px + sh_ky[m] * it.py + sh_kz[m] * it.pz
                 + {sh_ph[m], 16'h0000};
            c = cos_q15(th);
            p = longint'(sh_ax[m]) * c;
            p = p >>> 15;
            acx = acx + p[47:0];
            p = longint'(sh_ay[m]) * c;
            p = p >>> 15;
            acy = acy + p[47:0];
            p = longint'(sh_az[m]) * c;
            p = p >>> 15;
            acz = acz + p[47:0];
        end
        brms = longint'(sh_brms);
        sx = longint'($signed(acx)) * brms;
        sy = longint'($signed(acy)) * brms;
        sz = longint'($signed(acz)) * brms;
        f.fx = clamp32(sx >>> 8);
        f.fy = clamp32(sy >>> 8);
        f.fz = clamp32((sz >>> 8) + longint'(sh_bias));
        return f;
    endfunction

    function automatic mode_item_t load_item(input logic [11:0] idx,
                                             input logic [31:0] k1, k2, k3,
                                             input logic [15:0] ph,
                                             input logic [23:0] a1, a2, a3);
        mode_item_t it;
        it = '{cmd: tfms_pkg::CMD_LOAD, idx: idx, kx: k1, ky: k2, kz: k3, ph: ph,
               ax: a1, ay: a2, az: a3, px: '0, py: '0, pz: '0};
        return it;
    endfunction

    function automatic mode_item_t eval_item(input logic [31:0] p1, p2, p3);
        mode_item_t it;
        it = '{cmd: tfms_pkg::CMD_EVAL, idx: '0, kx: '0, ky: '0, kz: '0, ph: '0,
               ax: '0, ay: '0, az: '0, px: p1, py: p2, pz: p3};
        return it;
    endfunction

    function automatic mode_item_t rand_load(input logic [11:0] idx);
        return load_item(idx, $urandom, $urandom, $urandom, 16'($urandom),
                         24'($urandom), 24'($urandom), 24'($urandom));
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] ri, input logic [31:0] rv);
        stim_row_t r;
        r = '{is_cfg: 1'b1, reg_idx: ri, reg_val: rv, it: eval_item(0, 0, 0),
              typed: 1'b0, want: '{0, 0, 0}};
        return r;
    endfunction

    function automatic stim_row_t item_row(input mode_item_t it, input logic typed,
                                           input logic [31:0] wx, wy, wz);
        stim_row_t r;
        r = '{is_cfg: 1'b0, reg_idx: '0, reg_val: '0, it: it, typed: typed,
              want: '{wx, wy, wz}};
        return r;
    endfunction

    // Present one transaction in bursts; keep valid high between burst items
    task automatic offer(input mode_item_t it, input logic typed, input field_t want);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {4'b0, it.pz, it.py, it.px, it.az, it.ay, it.ax, it.ph,
                          it.kz, it.ky, it.kx, it.idx};
        do @(posedge clk); while (!s_axis_tready);
        burst_left--;
        if (it.cmd == tfms_pkg::CMD_EVAL)
            pending_fields.push_back(typed ? want : sum_modes(it));
        else
        begin
            sh_kx[it.idx] = it.kx;
            sh_ky[it.idx] = it.ky;
            sh_kz[it.idx] = it.kz;
            sh_ph[it.idx] = it.ph;
            sh_ax[it.idx] = it.ax;
            sh_ay[it.idx] = it.ay;
            sh_az[it.idx] = it.az;
        end
    endtask

    // Drop valid and wait until the block has gone quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_fields.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] ri, input logic [31:0] rv);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= rv;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (ri)
            tfms_pkg::CFG_BRMS:  sh_brms  = rv[15:0];
            tfms_pkg::CFG_BIAS:  sh_bias  = rv;
            tfms_pkg::CFG_MODES: sh_modes = rv[12:0];
            default: ;
        endcase
    endtask

    // Receiver: stall on a pattern of always, half and mostly ready, plus one
    // long hold-off on request so the block backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_taken    <= 1'b0;
            hold_left     <= 0;
        end
        else
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken <= 1'b1;
                hold_left  <= HOLD_CYCLES;
            end
            else if (hold_left > 0)
                hold_left <= hold_left - 1;

            if (hold_left > 1 || (hold_req && !hold_taken))
                m_axis_tready <= 1'b0;
            else
                case ((cyc / 256) % 3)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase

            // Compare each accepted result against the oldest expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_fields.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", m_axis_tdata);
                end
                else
                begin
                    field_t w;
                    w = pending_fields.pop_front();
                    if (m_axis_tdata[31:0] !== w.fx || m_axis_tdata[63:32] !== w.fy
                        || m_axis_tdata[95:64] !== w.fz)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("field mismatch: want x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                     w.fx, w.fy, w.fz, $signed(m_axis_tdata[31:0]),
                                     $signed(m_axis_tdata[63:32]),
                                     $signed(m_axis_tdata[95:64]));
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        mode_item_t it;
        field_t none;
        int phase_len;
        int roll;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_req      = 1'b0;
        burst_left    = 0;
        items_sent    = 0;
        none          = '{0, 0, 0};
        sh_brms       = tfms_pkg::BRMS_RST;
        sh_bias       = 0;
        sh_modes      = tfms_pkg::MODES_RST;

        // Directed part. No mode is loaded yet, so evaluate with a zero mode
        // count first: the result is the bias alone.
        directed.push_back(cfg_row(tfms_pkg::CFG_MODES, 0));
        directed.push_back(item_row(eval_item(32'h7FFF_FFFF, 32'h8000_0000, 0), 1,
                                    0, 0, 0));
        directed.push_back(cfg_row(tfms_pkg::CFG_BIAS, 32'h7FFF_FFFF));
        directed.push_back(item_row(eval_item(0, 0, 0), 1, 0, 0, 32'h7FFF_FFFF));
        directed.push_back(cfg_row(tfms_pkg::CFG_BIAS, 32'h8000_0000));
        directed.push_back(item_row(eval_item(-1, -1, -1), 1, 0, 0, 32'h8000_0000));
        directed.push_back(item_row(load_item(0, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                                    16'hFFFF, 24'h7FFFFF, 24'h800000, 0), 0, 0, 0, 0));
        directed.push_back(item_row(load_item(1, 32'h8000_0000, 32'h7FFF_FFFF, -1,
                                    16'h0000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF),
                                    0, 0, 0, 0));
        directed.push_back(item_row(load_item(12'hFFF, -1, -1, -1, 16'h4000,
                                    24'h400000, 24'hC00000, 24'h000001), 0, 0, 0, 0));
        directed.push_back(cfg_row(tfms_pkg::CFG_MODES, 1));
        directed.push_back(cfg_row(tfms_pkg::CFG_BIAS, 0));
        directed.push_back(cfg_row(CFG_UNUSED, 32'hFFFF_FFFF));
        directed.push_back(item_row(eval_item(0, 0, 0), 0, 0, 0, 0));
        directed.push_back(item_row(eval_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                                    0, 0, 0, 0));
        directed.push_back(cfg_row(tfms_pkg::CFG_MODES, 2));
        directed.push_back(cfg_row(tfms_pkg::CFG_BRMS, 16'hFFFF));
        directed.push_back(item_row(eval_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
                                    0, 0, 0, 0));
        directed.push_back(item_row(eval_item(3, -5, 7), 0, 0, 0, 0));
        // Zero strength wipes the sum out
        directed.push_back(cfg_row(tfms_pkg::CFG_BRMS, 0));
        directed.push_back(item_row(eval_item(12345, 678, -9), 1, 0, 0, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                write_reg(directed[i].reg_idx, directed[i].reg_val);
            else
            begin
                offer(directed[i].it, directed[i].typed, directed[i].want);
                items_sent++;
            end
        end

        // Fill the low entries so every mode count used below reads loaded rows
        for (int m = 0; m < FILL_MODES; m++)
            offer(rand_load(12'(m)), 0, none);
        items_sent += FILL_MODES;

        // Random phases: new register settings, then a mix of loads and
        // evaluations at mostly small mode counts.
        for (int ph = 0; items_sent < TARGET_ITEMS; ph++)
        begin
            roll = $urandom_range(0, 9);
            write_reg(tfms_pkg::CFG_BRMS, (roll == 0) ? 32'hFFFF : (roll == 1) ? 0 : $urandom);
            roll = $urandom_range(0, 9);
            write_reg(tfms_pkg::CFG_BIAS, (roll == 0) ? 32'h7FFF_FFFF
                              : (roll == 1) ? 32'h8000_0000 : $urandom);
            roll = $urandom_range(0, 19);
            write_reg(tfms_pkg::CFG_MODES,
                      (roll == 0) ? 0 : (roll == 1) ? 1 : $urandom_range(1, 12));
            if (ph == 2)
                hold_req = 1'b1;
            phase_len = $urandom_range(6, 12);
            for (int n = 0; n < phase_len; n++)
            begin
                if ($urandom_range(0, 9) < 6)
                    it = eval_item($urandom, $urandom, $urandom);
                else
                    it = rand_load(12'(($urandom_range(0, 3) == 0) ? $urandom
                                                                   : $urandom_range(0, 15)));
                offer(it, 0, none);
                items_sent++;
            end
        end

        settle();
        if (mismatches == 0 && pending_fields.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> turbulent_field_mode_summation.f
sv/tfms_pkg.sv
sv/tfms_ram.sv
sv/turbulent_field_mode_summation.sv
sv/tfms_checker.sv
dv/tb_turbulent_field_mode_summation.sv
